@@ rtl/tq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tq_pkg: shared types and constants
// Opcodes, status codes, store sizes and controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package tq_pkg;
  localparam int MaxTeams    = 16;
  localparam int TeamW       = 4;
  localparam int ElemW       = 20;
  localparam int MemberDepth = 1024;
  localparam int MemberAw    = 10;
  localparam int SlotAw      = 4;
  localparam int SlotDepth   = 16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_ENQ = 2'd1, OP_DEQ = 2'd2, OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_UNKNOWN = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;   // latch request fields
    logic load_wr;   // write membership entry
    logic scan_clr;  // start lookup
    logic scan_rd;   // issue one membership read
    logic enq_do;    // append to team FIFO
    logic deq_rd;    // read team slot for dequeue
    logic deq_do;    // commit dequeue
  } cmd_t;

  typedef struct packed {
    logic                   table_full;
    logic                   scan_last;   // all entries read and compared
    logic                   found;
    logic                   team_full;
    logic                   order_empty;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/tq_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tq_datapath: storage and update logic
// Membership memories, team slot memory, per-team rings and the team order.
// ----------------------------------------------------------------------------
module tq_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire tq_pkg::cmd_t             cmd,
  input  wire logic [tq_pkg::ElemW-1:0] element,
  input  wire logic [tq_pkg::TeamW-1:0] team_id,
  output tq_pkg::sts_t                  sts,
  output logic      [tq_pkg::ElemW-1:0] deq_data
);
  logic [tq_pkg::ElemW-1:0] member_value [tq_pkg::MemberDepth];
  logic [tq_pkg::TeamW-1:0] member_team  [tq_pkg::MemberDepth];
  logic [tq_pkg::ElemW-1:0] team_slots   [tq_pkg::MaxTeams*tq_pkg::SlotDepth];
  logic [tq_pkg::ElemW-1:0] elem_q;
  logic [tq_pkg::TeamW-1:0] tid_q;
  logic [tq_pkg::MemberAw:0] member_count;
  logic [tq_pkg::MemberAw:0] scan_addr;
  logic                     rd_pend;
  logic [tq_pkg::ElemW-1:0] rd_val;
  logic [tq_pkg::TeamW-1:0] rd_team;
  logic                     found;
  logic [tq_pkg::TeamW-1:0] best;
  logic [tq_pkg::SlotAw-1:0] team_head [tq_pkg::MaxTeams];
  logic [tq_pkg::SlotAw:0]   team_fill [tq_pkg::MaxTeams];
  logic [tq_pkg::TeamW-1:0]  order_ring [tq_pkg::MaxTeams];
  logic [tq_pkg::TeamW-1:0]  order_head;
  logic [tq_pkg::TeamW:0]    order_fill;
  logic [tq_pkg::TeamW-1:0]  front;
  logic [tq_pkg::SlotAw-1:0] wpos;
  logic [tq_pkg::TeamW-1:0]  opos;

  assign front = order_ring[order_head];
  assign wpos  = team_head[best] + team_fill[best][tq_pkg::SlotAw-1:0];
  assign opos  = order_head + order_fill[tq_pkg::TeamW-1:0];

  assign sts.table_full  = member_count[tq_pkg::MemberAw];
  assign sts.scan_last   = (scan_addr >= member_count) && !rd_pend;
  assign sts.found       = found;
  assign sts.team_full   = team_fill[best][tq_pkg::SlotAw];
  assign sts.order_empty = (order_fill == '0);

  // Memory ports: one write and one registered read per store.
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      member_value[member_count[tq_pkg::MemberAw-1:0]] <= elem_q;
      member_team[member_count[tq_pkg::MemberAw-1:0]]  <= tid_q;
    end
    rd_val  <= member_value[scan_addr[tq_pkg::MemberAw-1:0]];
    rd_team <= member_team[scan_addr[tq_pkg::MemberAw-1:0]];
    if (cmd.enq_do) team_slots[{best, wpos}] <= elem_q;
    deq_data <= team_slots[{front, team_head[front]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elem_q <= element;
      tid_q  <= team_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member_count <= '0;
      scan_addr    <= '0;
      rd_pend      <= 1'b0;
      found        <= 1'b0;
      best         <= '0;
      order_head   <= '0;
      order_fill   <= '0;
      for (int i = 0; i < tq_pkg::MaxTeams; i++) begin
        team_head[i] <= '0;
        team_fill[i] <= '0;
      end
    end else begin
      if (cmd.load_wr) member_count <= member_count + 1'b1;
      // Scan pipeline: address issued, data compared in the next cycle.
      rd_pend <= cmd.scan_rd && (scan_addr < member_count);
      if (cmd.scan_clr) begin
        scan_addr <= '0;
        found     <= 1'b0;
      end else if (cmd.scan_rd && scan_addr < member_count) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (!cmd.scan_clr && rd_pend && rd_val == elem_q) begin
        if (!found || rd_team < best) best <= rd_team;
        found <= 1'b1;
      end
      if (cmd.enq_do) begin
        if (team_fill[best] == '0 && !order_fill[tq_pkg::TeamW]) begin
          order_ring[opos] <= best;
          order_fill <= order_fill + 1'b1;
        end
        team_fill[best] <= team_fill[best] + 1'b1;
      end
      if (cmd.deq_do) begin
        team_head[front] <= team_head[front] + 1'b1;
        team_fill[front] <= team_fill[front] - 1'b1;
        if (team_fill[front] == (tq_pkg::SlotAw+1)'(1)) begin
          order_head <= order_head + 1'b1;
          order_fill <= order_fill - 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/tq_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tq_controller: request sequencer
// Accepts one request, steps the datapath and holds the result until taken.
// ----------------------------------------------------------------------------
module tq_controller (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               op,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic      [1:0]               res_status,
  output logic                          res_hit,
  output tq_pkg::cmd_t                  cmd,
  input  wire tq_pkg::sts_t             sts
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_SCAN = 6'b000100,
    S_ENQ  = 6'b001000, S_DEQ  = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [1:0] status_next;
  logic       hit_next;
  logic       accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    status_next = res_status;
    hit_next    = res_hit;
    unique case (state)
      S_IDLE: begin
        cmd.capture  = accept;
        cmd.scan_clr = accept;
        if (accept) begin
          status_next = tq_pkg::ST_OK;
          hit_next    = 1'b0;
          unique case (op)
            tq_pkg::OP_LOAD: state_next = S_LOAD;
            tq_pkg::OP_ENQ:  state_next = S_SCAN;
            tq_pkg::OP_DEQ:  state_next = S_DEQ;
            default:         state_next = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        if (sts.table_full) status_next = tq_pkg::ST_FULL;
        else cmd.load_wr = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_next = S_ENQ;
      end
      S_ENQ: begin
        if (!sts.found) status_next = tq_pkg::ST_UNKNOWN;
        else if (sts.team_full) status_next = tq_pkg::ST_FULL;
        else cmd.enq_do = 1'b1;
        state_next = S_DONE;
      end
      S_DEQ: begin
        cmd.deq_rd = 1'b1;
        if (sts.order_empty) status_next = tq_pkg::ST_EMPTY;
        else begin
          cmd.deq_do = 1'b1;
          hit_next   = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!res_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= tq_pkg::ST_OK;
      res_hit    <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= status_next;
      res_hit    <= hit_next;
    end
  end
endmodule
`default_nettype wire

@@ rtl/team_queue_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// team_queue_unit: grouped FIFO (team queue)
// Membership table, per-team FIFOs and a team-order queue behind one port.
// ----------------------------------------------------------------------------
// One request at a time. An enqueue looks up the element among the N
// membership entries loaded (up to 1024): the lookup reads the membership
// memory one entry per cycle through its single read port, compares in the
// next cycle and keeps the lowest matching team. The result waits in the
// output register until taken; a new request is accepted in the cycle after.
// No clearing pass is needed.
module team_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [19:0] element,
  input  wire logic [3:0]  team_id,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [19:0]      out_element,
  output logic             out_valid,
  output logic [1:0]       status
);
  tq_pkg::cmd_t cmd;
  tq_pkg::sts_t sts;
  logic [19:0]  deq_data;
  logic         hit;

  tq_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .op,
    .res_valid, .res_stall, .res_status(status), .res_hit(hit),
    .cmd, .sts
  );

  tq_datapath u_dp (
    .clk, .rst, .cmd, .element, .team_id, .sts, .deq_data
  );

  // Latch the dequeued element; show it only while a hit is reported.
  logic [19:0] elem_hold;
  always_ff @(posedge clk) begin
    if (cmd.deq_rd) elem_hold <= deq_data;
  end
  assign out_valid   = hit;
  assign out_element = hit ? elem_hold : '0;
endmodule
`default_nettype wire

@@ rtl/tq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tq_checker: port-level checks
// Watches the handshake and result encoding on the top level.
// ----------------------------------------------------------------------------
module tq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [19:0] out_element,
  input wire logic        out_valid,
  input wire logic [1:0]  status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_element) && $stable(status))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("request accepted while result pending");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_element == 20'd0)
    else $error("nonzero element without hit");
  a_okhit: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == 2'd0)
    else $error("hit with error status");
endmodule

bind team_queue_unit tq_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_team_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_team_queue_unit: self-checking bench for the team queue
// A directed table covers the reset state, extreme elements, duplicate membership,
// unknown elements and empty dequeues. Random requests follow, biased toward known
// elements. A result is checked against the expected result written in its row if
// typed, else against a behavioral model of the table, per-team FIFOs and team order.
// ----------------------------------------------------------------------------
module tb_team_queue_unit;
  localparam int CycleLimit  = 1000000;
  localparam int RandomReqs  = 540;
  localparam int LongHold    = 300;

  typedef struct packed {
    logic [tq_pkg::ElemW-1:0] elem;
    logic                     valid;
    tq_pkg::status_t          st;
  } result_t;

  typedef struct {
    tq_pkg::op_t     op;
    int              elem;
    int              tid;
    bit              typed;  // expected result is written in the row
    int              x_elem;
    bit              x_valid;
    tq_pkg::status_t x_st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = tq_pkg::OP_NOP;
  logic [19:0] element = '0;
  logic [3:0]  team_id = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [19:0] out_element;
  logic        out_valid;
  logic [1:0]  status;

  team_queue_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .element(element), .team_id(team_id),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_element(out_element), .out_valid(out_valid), .status(status)
  );

  // Model state: membership table, per-team rings and the team order.
  int      member_elem [tq_pkg::MemberDepth];
  int      member_grp  [tq_pkg::MemberDepth];
  int      member_used;
  int      grp_slot    [tq_pkg::MaxTeams][tq_pkg::SlotDepth];
  int      grp_head    [tq_pkg::MaxTeams];
  int      grp_fill    [tq_pkg::MaxTeams];
  int      order_q     [tq_pkg::MaxTeams];
  int      order_head;
  int      order_fill;

  result_t pending_q[$];   // results still owed by the block
  int      errors      = 0;
  int      cycles      = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  bit      hold_now    = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Run the queue model for one request and return its result.
  function automatic result_t team_queue_step(tq_pkg::op_t o, int e, int t);
    result_t r;
    int      best;
    int      g;
    r = '{elem: '0, valid: 1'b0, st: tq_pkg::ST_OK};
    case (o)
      tq_pkg::OP_LOAD: begin
        if (member_used >= tq_pkg::MemberDepth) r.st = tq_pkg::ST_FULL;
        else begin
          member_elem[member_used] = e;
          member_grp[member_used]  = t;
          member_used++;
        end
      end
      tq_pkg::OP_ENQ: begin
        best = -1;
        for (int i = 0; i < member_used; i++)
          if (member_elem[i] == e && (best < 0 || member_grp[i] < best))
            best = member_grp[i];
        if (best < 0) r.st = tq_pkg::ST_UNKNOWN;
        else if (grp_fill[best] >= tq_pkg::SlotDepth) r.st = tq_pkg::ST_FULL;
        else begin
          if (grp_fill[best] == 0 && order_fill < tq_pkg::MaxTeams) begin
            order_q[(order_head + order_fill) % tq_pkg::MaxTeams] = best;
            order_fill++;
          end
          grp_slot[best][(grp_head[best] + grp_fill[best]) % tq_pkg::SlotDepth] = e;
          grp_fill[best]++;
        end
      end
      tq_pkg::OP_DEQ: begin
        if (order_fill == 0) r.st = tq_pkg::ST_EMPTY;
        else begin
          g = order_q[order_head];
          r.elem  = grp_slot[g][grp_head[g]];
          r.valid = 1'b1;
          grp_head[g] = (grp_head[g] + 1) % tq_pkg::SlotDepth;
          grp_fill[g]--;
          if (grp_fill[g] == 0) begin
            order_head = (order_head + 1) % tq_pkg::MaxTeams;
            order_fill--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request, hold it until taken, then log its expected result.
  task automatic send_request(tq_pkg::op_t o, int e, int t, bit typed,
                              result_t typed_res);
    result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    element  <= e[19:0];
    team_id  <= t[3:0];
    do @(posedge clk); while (in_stall);
    r = team_queue_step(o, e, t);
    if (typed) r = typed_res;
    pending_q = {pending_q, r};
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        res_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      res_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result elem=%0d valid=%0b status=%0d",
                 $time, out_element, out_valid, status);
        errors++;
      end else begin
        result_t x;
        x = pending_q.pop_front();
        if (out_element !== x.elem || out_valid !== x.valid || status !== x.st) begin
          $display({"%0t: mismatch expected elem=%0d valid=%0b status=%0d,",
                    " got elem=%0d valid=%0b status=%0d"},
                   $time, x.elem, x.valid, x.st, out_element, out_valid, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_team_queue_unit failed");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    result_t     typed_res;
    tq_pkg::op_t o;
    int          e, t, pick, enq_pct, deq_pct;

    member_used = 0;
    order_head  = 0;
    order_fill  = 0;
    foreach (grp_head[i]) begin
      grp_head[i] = 0;
      grp_fill[i] = 0;
    end

    // Directed: reset state, extremes, duplicate membership, unknown element,
    // top element bit, empty dequeue, idle opcode. Team 0 leads the order,
    // then team 15, the duplicate (lowest team 3), then team 6.
    rows = '{
      '{tq_pkg::OP_DEQ,       0,  0, 1,      0, 0, tq_pkg::ST_EMPTY},
      '{tq_pkg::OP_NOP,       0,  0, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_LOAD, 999999,  0, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_LOAD,      0, 15, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_LOAD,      5,  9, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_LOAD,      5,  3, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_LOAD, 524288,  6, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_ENQ,     123,  0, 1,      0, 0, tq_pkg::ST_UNKNOWN},
      '{tq_pkg::OP_ENQ,  999999,  0, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_ENQ,       0,  7, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_ENQ,       5,  0, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_ENQ,  999999, 15, 1,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_ENQ,  524288,  0, 0,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_DEQ,       0,  0, 1, 999999, 1, tq_pkg::ST_OK},
      '{tq_pkg::OP_DEQ,       0,  0, 1, 999999, 1, tq_pkg::ST_OK},
      '{tq_pkg::OP_DEQ,       0,  0, 1,      0, 1, tq_pkg::ST_OK},
      '{tq_pkg::OP_DEQ,       0,  0, 1,      5, 1, tq_pkg::ST_OK},
      '{tq_pkg::OP_DEQ,       0,  0, 0,      0, 0, tq_pkg::ST_OK},
      '{tq_pkg::OP_DEQ,       0,  0, 1,      0, 0, tq_pkg::ST_EMPTY},
      '{tq_pkg::OP_NOP,  999999, 15, 1,      0, 0, tq_pkg::ST_OK}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 11;
    rx_idle_pct = 71;
    foreach (rows[i]) begin
      typed_res = '{elem: rows[i].x_elem[19:0], valid: rows[i].x_valid, st: rows[i].x_st};
      send_request(rows[i].op, rows[i].elem, rows[i].tid, rows[i].typed, typed_res);
    end

    // Random: alternate enqueue-heavy and dequeue-heavy stretches so team
    // FIFOs both fill up and drain. Keep the table small to bound lookups.
    for (int n = 0; n < RandomReqs; n++) begin
      if (n == 200) begin
        tx_idle_pct = 71;
        rx_idle_pct = 11;
      end
      if (n == 400) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (n == 150) hold_now = 1'b1;   // receiver holds off while sender offers
      if (n == 350) begin              // drain everything before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
      end
      enq_pct = ((n / 60) % 2 == 0) ? 65 : 25;
      deq_pct = ((n / 60) % 2 == 0) ? 20 : 60;
      pick = $urandom_range(99);
      t = $urandom_range(15);
      e = $urandom_range(999999);
      if (member_used < 90 && pick < 12) o = tq_pkg::OP_LOAD;
      else if (pick < 12 + enq_pct) begin
        o = tq_pkg::OP_ENQ;
        if (member_used > 0 && $urandom_range(99) < 85)
          e = member_elem[$urandom_range(member_used - 1)];
      end else if (pick < 12 + enq_pct + deq_pct) o = tq_pkg::OP_DEQ;
      else o = tq_pkg::OP_NOP;
      send_request(o, e, t, 1'b0, '0);
    end

    // Finish with lookups over the whole loaded table and one dequeue, then six more dequeues.
    for (int n = 0; n < 8; n++) begin
      e = member_elem[$urandom_range(member_used - 1)];
      send_request(n == 3 ? tq_pkg::OP_DEQ : tq_pkg::OP_ENQ, e, 0, 1'b0, '0);
    end
    send_request(tq_pkg::OP_ENQ, 1000000 - 1 - 0, 0, 1'b0, '0);
    for (int n = 0; n < 6; n++) send_request(tq_pkg::OP_DEQ, 0, 0, 1'b0, '0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb_team_queue_unit passed");
    else $display("tb_team_queue_unit failed");
    $finish;
  end
endmodule

@@ team_queue_unit.f @@
rtl/tq_pkg.sv
rtl/tq_datapath.sv
rtl/tq_controller.sv
rtl/team_queue_unit.sv
rtl/tq_checker.sv
tb/sv/tb_team_queue_unit.sv
